[design/four_lane_byte_hash_top_macros.svh]
// Assertion macros for the four-lane byte hash block.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef FOUR_LANE_BYTE_HASH_TOP_MACROS_SVH
`define FOUR_LANE_BYTE_HASH_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FLH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("flh assertion failed");

// Next-cycle implication, checked outside reset.
`define FLH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("flh assertion failed");

`endif

[design/flh_pkg.sv]
// Package for the four-lane byte hash: constants and the multiplier request types.
// No dependencies.
package flh_pkg;

    localparam int unsigned LANE_W = 64;
    localparam int unsigned HALF_W = 32;

    localparam logic [LANE_W-1:0] SEED0      = 64'hcbf29ce484222325;
    localparam logic [LANE_W-1:0] SEED1      = 64'h00000100000001b3;
    localparam logic [LANE_W-1:0] SEED2      = 64'h84222325cbf29ce4;
    localparam logic [LANE_W-1:0] SEED3      = 64'h9e3779b97f4a7c15;
    localparam logic [LANE_W-1:0] FNV_PRIME  = 64'h00000100000001b3;
    localparam logic [LANE_W-1:0] GOLDEN_MUL = 64'h9e3779b97f4a7c15;

    typedef struct packed {
        logic              start;
        logic [LANE_W-1:0] a;
        logic [LANE_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [LANE_W-1:0] p;
    } t_mul_rsp;

endpackage

[design/flh_if.sv]
// Handshake interfaces for the input byte items and the digest items.
// No dependencies.
interface flh_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;

    modport source (output valid, output data_byte, output has_byte, output last,
                    input ready);
    modport sink (input valid, input data_byte, input has_byte, input last,
                  output ready);
endinterface

interface flh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] digest_word0;
    logic [63:0] digest_word1;
    logic [63:0] digest_word2;
    logic [63:0] digest_word3;

    modport source (output valid, output digest_word0, output digest_word1,
                    output digest_word2, output digest_word3, input ready);
    modport sink (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, output ready);
endinterface

[design/flh_mul.sv]
// Iterative 64x64 multiplier giving the low 64 product bits from one 32x32 multiplier.
// Depends on flh_pkg.
module flh_mul
    import flh_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [1:0]        r_step;
    logic [LANE_W-1:0] r_a;
    logic [LANE_W-1:0] r_b;
    logic [LANE_W-1:0] r_prod;
    logic [LANE_W-1:0] r_acc;

    logic [HALF_W-1:0] w_ma;
    logic [HALF_W-1:0] w_mb;
    logic [LANE_W-1:0] w_prod;
    logic [LANE_W-1:0] w_cross;

    always_comb begin
        case (r_step)
            2'd1: begin
                w_ma = r_a[LANE_W-1:HALF_W];
                w_mb = r_b[HALF_W-1:0];
            end
            2'd2: begin
                w_ma = r_a[HALF_W-1:0];
                w_mb = r_b[LANE_W-1:HALF_W];
            end
            default: begin
                w_ma = r_a[HALF_W-1:0];
                w_mb = r_b[HALF_W-1:0];
            end
        endcase
    end

    assign w_prod  = LANE_W'(w_ma) * LANE_W'(w_mb);
    assign w_cross = {r_prod[HALF_W-1:0], {HALF_W{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_a <= i_req.a;
            r_b <= i_req.b;
        end
        if (r_busy) begin
            r_prod <= w_prod;
            case (r_step)
                2'd1:    r_acc <= r_prod;
                default: r_acc <= r_acc + w_cross;
            endcase
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

[design/four_lane_byte_hash_top.sv]
// Top level of the four-lane byte hash: lane ring, sequencer and digest register.
// Depends on flh_pkg, flh_if, flh_mul and four_lane_byte_hash_top_macros.svh.
//
//  channel   direction  payload
//  i_in      sink       data_byte[7:0], has_byte, last
//  o_out     source     digest_word0..3 [63:0]
//
// For a byte item the 64-bit multiply runs as three 32x32 partial products on one
// multiplier. An item with last then rotates the lane ring into order, runs four
// finalization multiplies, and loads the digest once the digest register is free.
// An item with neither byte nor last is accepted and leaves the lanes as they are.
// Reset reseeds the lanes at once. A finished digest waits in its register while
// the next message is absorbed.
`include "four_lane_byte_hash_top_macros.svh"

module four_lane_byte_hash_top
    import flh_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    flh_in_if.sink    i_in,
    flh_out_if.source o_out
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ABS   = 5'b00010,
        S_ALIGN = 5'b00100,
        S_FIN   = 5'b01000,
        S_EMIT  = 5'b10000
    } t_state;

    t_state            r_state, n_state;
    logic [LANE_W-1:0] r_ring [0:3];
    logic [LANE_W-1:0] n_ring [0:3];
    logic [1:0]        r_pos, n_pos;
    logic [1:0]        r_cnt, n_cnt;
    logic              r_last, n_last;
    logic              r_out_valid, n_out_valid;
    logic              w_load;
    logic [LANE_W-1:0] r_dw0, r_dw1, r_dw2, r_dw3;
    logic [LANE_W-1:0] w_mix;
    logic              w_in_acc;
    t_mul_req          w_mul_req;
    t_mul_rsp          w_mul_rsp;

    flh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mul_req),
        .o_rsp   (w_mul_rsp)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_mix      = r_ring[0] ^ (r_ring[1] << 13) ^ (r_ring[3] >> 7);

    always_comb begin
        n_state     = r_state;
        n_ring      = r_ring;
        n_pos       = r_pos;
        n_cnt       = r_cnt;
        n_last      = r_last;
        w_load      = 1'b0;
        w_mul_req.start = 1'b0;
        w_mul_req.a     = r_ring[0] ^ {{(LANE_W-8){1'b0}}, i_in.data_byte};
        w_mul_req.b     = FNV_PRIME;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_last = i_in.last;
                    if (i_in.has_byte) begin
                        w_mul_req.start = 1'b1;
                        n_state = S_ABS;
                    end else if (i_in.last) begin
                        n_state = S_ALIGN;
                    end
                end
            end
            S_ABS: begin
                if (w_mul_rsp.done) begin
                    n_ring[0] = r_ring[1] ^ (w_mul_rsp.p >> 17);
                    n_ring[1] = r_ring[2];
                    n_ring[2] = r_ring[3];
                    n_ring[3] = w_mul_rsp.p;
                    n_pos     = r_pos + 2'd1;
                    n_state   = r_last ? S_ALIGN : S_IDLE;
                end
            end
            S_ALIGN: begin
                if (r_pos != 2'd0) begin
                    n_ring[0] = r_ring[1];
                    n_ring[1] = r_ring[2];
                    n_ring[2] = r_ring[3];
                    n_ring[3] = r_ring[0];
                    n_pos     = r_pos + 2'd1;
                end else begin
                    w_mul_req.start = 1'b1;
                    w_mul_req.a     = w_mix;
                    w_mul_req.b     = GOLDEN_MUL;
                    n_state         = S_FIN;
                end
            end
            S_FIN: begin
                if (w_mul_rsp.done) begin
                    n_ring[0] = r_ring[1];
                    n_ring[1] = r_ring[2];
                    n_ring[2] = r_ring[3];
                    n_ring[3] = w_mul_rsp.p;
                    n_cnt     = r_cnt + 2'd1;
                    n_state   = (r_cnt == 2'd3) ? S_EMIT : S_ALIGN;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_out.ready) begin
                    w_load    = 1'b1;
                    n_ring[0] = SEED0;
                    n_ring[1] = SEED1;
                    n_ring[2] = SEED2;
                    n_ring[3] = SEED3;
                    n_pos     = 2'd0;
                    n_cnt     = 2'd0;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = w_load ? 1'b1 : (r_out_valid && !o_out.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ring[0]   <= SEED0;
            r_ring[1]   <= SEED1;
            r_ring[2]   <= SEED2;
            r_ring[3]   <= SEED3;
            r_pos       <= 2'd0;
            r_cnt       <= 2'd0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ring      <= n_ring;
            r_pos       <= n_pos;
            r_cnt       <= n_cnt;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dw0 <= r_ring[0];
            r_dw1 <= r_ring[1];
            r_dw2 <= r_ring[2];
            r_dw3 <= r_ring[3];
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.digest_word0 = r_dw0;
    assign o_out.digest_word1 = r_dw1;
    assign o_out.digest_word2 = r_dw2;
    assign o_out.digest_word3 = r_dw3;

    `FLH_ASSERT_NOW(a_ready_mul_idle, i_in.ready, !w_mul_rsp.busy && !w_mul_rsp.done)
    `FLH_ASSERT_NOW(a_done_in_wait, w_mul_rsp.done, r_state == S_ABS || r_state == S_FIN)
    `FLH_ASSERT_NEXT(a_emit_reseeds, w_load, r_pos == 2'd0 && r_cnt == 2'd0 && r_out_valid)

endmodule

[test/four_lane_byte_hash_top_test.sv]
// Testbench for four_lane_byte_hash_top: directed messages, then random messages under
// four idle and stall patterns, each digest checked against a built-in lane predictor.
// Depends on flh_pkg, flh_if and the design files.
module four_lane_byte_hash_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import flh_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned PHASE_ITEMS = 283;
    localparam int unsigned PHASE_COUNT = 4;
    localparam int unsigned SENDER_IDLE [PHASE_COUNT] = '{0, 45, 0, 22};
    localparam int unsigned RECEIVER_STALL [PHASE_COUNT] = '{0, 0, 45, 22};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       last;
    } hash_item_t;

    typedef logic [3:0][LANE_W-1:0] digest_t;

    localparam int unsigned DIRECTED_COUNT = 23;
    localparam hash_item_t DIRECTED_ITEMS [DIRECTED_COUNT] = '{
        '{8'h00, 1'b0, 1'b1},
        '{8'h5a, 1'b0, 1'b0},
        '{8'hff, 1'b0, 1'b1},
        '{8'h00, 1'b1, 1'b1},
        '{8'hff, 1'b1, 1'b1},
        '{8'hff, 1'b1, 1'b0},
        '{8'h00, 1'b1, 1'b0},
        '{8'haa, 1'b1, 1'b0},
        '{8'h55, 1'b1, 1'b0},
        '{8'h80, 1'b1, 1'b1},
        '{8'h01, 1'b1, 1'b0},
        '{8'h02, 1'b1, 1'b0},
        '{8'h03, 1'b1, 1'b0},
        '{8'h00, 1'b0, 1'b1},
        '{8'h7f, 1'b1, 1'b0},
        '{8'hff, 1'b0, 1'b0},
        '{8'h80, 1'b1, 1'b1},
        '{8'h00, 1'b0, 1'b1},
        '{8'h00, 1'b0, 1'b1},
        '{8'h01, 1'b1, 1'b0},
        '{8'hfe, 1'b1, 1'b0},
        '{8'h10, 1'b1, 1'b0},
        '{8'hef, 1'b1, 1'b1}
    };

    logic clk;
    logic rst_n;

    flh_in_if  hash_in ();
    flh_out_if digest_out ();

    four_lane_byte_hash_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (hash_in),
        .o_out   (digest_out)
    );

    logic [LANE_W-1:0] hash_lanes [4];
    logic [1:0]        hash_pos;
    digest_t           expected_digests [$];

    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int unsigned items_sent = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;

    function automatic void reseed_lanes();
        hash_lanes[0] = SEED0;
        hash_lanes[1] = SEED1;
        hash_lanes[2] = SEED2;
        hash_lanes[3] = SEED3;
        hash_pos = 2'd0;
    endfunction

    function automatic void absorb_byte(input logic [7:0] b);
        logic [1:0] nxt;
        nxt = hash_pos + 2'd1;
        hash_lanes[hash_pos] = (hash_lanes[hash_pos] ^ {56'd0, b}) * FNV_PRIME;
        hash_lanes[nxt] = hash_lanes[nxt] ^ (hash_lanes[hash_pos] >> 17);
        hash_pos = nxt;
    endfunction

    function automatic void hash_accept(input hash_item_t it);
        digest_t d;
        if (it.has_byte) begin
            absorb_byte(it.data_byte);
        end
        if (it.last) begin
            for (int k = 0; k < 4; k++) begin
                hash_lanes[k] = hash_lanes[k] ^ (hash_lanes[(k + 1) % 4] << 13);
                hash_lanes[k] = hash_lanes[k] ^ (hash_lanes[(k + 3) % 4] >> 7);
                hash_lanes[k] = hash_lanes[k] * GOLDEN_MUL;
            end
            for (int k = 0; k < 4; k++) begin
                d[k] = hash_lanes[k];
            end
            expected_digests.push_back(d);
            reseed_lanes();
        end
    endfunction

    function automatic void check_digest(input digest_t got);
        digest_t want;
        if (expected_digests.size() == 0) begin
            $display("%0t: digest with no message pending, expected none, got %h", $time, got);
            mismatch_count++;
            return;
        end
        want = expected_digests.pop_front();
        for (int k = 0; k < 4; k++) begin
            if (want[k] !== got[k]) begin
                $display("%0t: digest_word%0d expected %h got %h", $time, k, want[k], got[k]);
                mismatch_count++;
            end
        end
    endfunction

    task automatic drive_item(input hash_item_t it);
        while ($urandom_range(99) < sender_idle_pct) begin
            hash_in.valid <= 1'b0;
            @(posedge clk);
        end
        hash_in.valid     <= 1'b1;
        hash_in.data_byte <= it.data_byte;
        hash_in.has_byte  <= it.has_byte;
        hash_in.last      <= it.last;
        @(posedge clk);
        while (!hash_in.ready) @(posedge clk);
        if (it.has_byte || it.last) begin
            items_sent++;
        end
    endtask

    task automatic wait_for_digests();
        hash_in.valid <= 1'b0;
        do @(posedge clk); while (expected_digests.size() != 0);
    endtask

    task automatic send_message();
        int unsigned len;
        int unsigned pick;
        bit          ends_empty;
        pick = $urandom_range(99);
        if (pick < 5) begin
            len = 0;
        end else if (pick < 90) begin
            len = $urandom_range(16, 1);
        end else begin
            len = $urandom_range(64, 17);
        end
        ends_empty = (len == 0) || ($urandom_range(3) == 0);
        for (int unsigned i = 0; i < len; i++) begin
            if ($urandom_range(9) == 0) begin
                drive_item('{8'($urandom), 1'b0, 1'b0});
            end
            drive_item('{8'($urandom), 1'b1, (!ends_empty && i == len - 1)});
        end
        if (ends_empty) begin
            drive_item('{8'($urandom), 1'b0, 1'b1});
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if (digest_out.valid && digest_out.ready) begin
                check_digest({digest_out.digest_word3, digest_out.digest_word2,
                              digest_out.digest_word1, digest_out.digest_word0});
            end
            if (hash_in.valid && hash_in.ready) begin
                hash_accept('{hash_in.data_byte, hash_in.has_byte, hash_in.last});
            end
        end else begin
            reseed_lanes();
        end
        digest_out.ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    initial begin
        int unsigned phase_start;
        rst_n              <= 1'b0;
        hash_in.valid      <= 1'b0;
        hash_in.data_byte  <= 8'h00;
        hash_in.has_byte   <= 1'b0;
        hash_in.last       <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int unsigned i = 0; i < DIRECTED_COUNT; i++) begin
            drive_item(DIRECTED_ITEMS[i]);
        end
        wait_for_digests();

        for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
            sender_idle_pct = SENDER_IDLE[p];
            receiver_stall_pct = RECEIVER_STALL[p];
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                send_message();
            end
            wait_for_digests();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
